// ----- rtl/tmg_pkg.sv -----
// tmg_pkg: shared types, codes and helper functions for the thermal migration gate.
// No dependencies; imported by tmg_cfg_regs, tmg_ctrl and thermal_migration_gate_core.
package tmg_pkg;

  localparam int NUM_CORES_DEF = 64;

  localparam int CORE_W     = 6;
  localparam int TEMP_W     = 12;
  localparam int RES_W      = 16;
  localparam int POW_W      = 16;
  localparam int PROD_W     = RES_W + POW_W;
  localparam int TIME_W     = 64;
  localparam int CD_W       = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PRED_SHIFT = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_BAND       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_TEMP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_RES      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_DELTA   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_DELTA = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_NS      = 3'd6;

  // operations
  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  // block reasons
  localparam logic [1:0] REASON_NONE      = 2'd0;
  localparam logic [1:0] REASON_DEST_COOL = 2'd1;
  localparam logic [1:0] REASON_SRC_COOL  = 2'd2;
  localparam logic [1:0] REASON_DROP      = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [CORE_W-1:0] from_core;
    logic [CORE_W-1:0] to_core;
    logic [TEMP_W-1:0] src_temp;
    logic [TEMP_W-1:0] dest_temp;
    logic [POW_W-1:0]  source_power;
    logic [POW_W-1:0]  dest_power;
    logic              source_power_ok;
    logic              dest_power_ok;
    logic [TIME_W-1:0] now_ns;
  } tmg_item_t;

  typedef struct packed {
    logic       allowed;
    logic [1:0] block_reason;
  } tmg_result_t;

  typedef struct packed {
    logic [TEMP_W-1:0] critical_temp;
    logic [TEMP_W-1:0] guard_band;
    logic [TEMP_W-1:0] ambient_temp;
    logic [RES_W-1:0]  thermal_res;
    logic [TEMP_W-1:0] critical_delta;
    logic [TEMP_W-1:0] hysteresis_delta;
    logic [CD_W-1:0]   cooldown_ns;
  } tmg_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_TO,
    ST_RD_FROM,
    ST_EVAL,
    ST_WR_FROM,
    ST_WR_TO
  } tmg_state_t;

  // sequencer strobes toward the datapath
  typedef struct packed {
    logic busy;
    logic clear;
    logic rd_to;
    logic rd_from;
    logic eval;
    logic wr_from;
    logic wr_to;
  } tmg_ctl_t;

  // max(measured, min(4095, ambient + (R*P >> 12))); measured alone when prediction is off
  function automatic logic [TEMP_W-1:0] tmg_predict(
    input logic [TEMP_W-1:0] temp,
    input logic [PROD_W-1:0] prod,
    input logic              ok,
    input logic [RES_W-1:0]  res,
    input logic [TEMP_W-1:0] amb
  );
    logic [PROD_W-PRED_SHIFT:0] steady;
    logic [TEMP_W-1:0]          sat;
    steady = {{(PROD_W-PRED_SHIFT+1-TEMP_W){1'b0}}, amb}
           + {1'b0, prod[PROD_W-1:PRED_SHIFT]};
    sat = (|steady[PROD_W-PRED_SHIFT:TEMP_W]) ? '1 : steady[TEMP_W-1:0];
    if (!ok || res == '0) begin
      tmg_predict = temp;
    end else begin
      tmg_predict = (sat > temp) ? sat : temp;
    end
  endfunction

  // time before the stamp counts as cooling; all-ones stamp means never moved
  function automatic logic tmg_cooling(
    input logic [TIME_W-1:0] last,
    input logic [TIME_W-1:0] now,
    input logic [CD_W-1:0]   cd
  );
    logic [TIME_W:0] diff;
    diff = {1'b0, now} - {1'b0, last};
    tmg_cooling = (cd != '0) && (last != '1) &&
                  (diff[TIME_W] ||
                   ((diff[TIME_W-1:CD_W] == '0) && (diff[CD_W-1:0] < cd)));
  endfunction

endpackage

// ----- rtl/tmg_ram.sv -----
// tmg_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies.
module tmg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tmg_cfg_regs.sv -----
// tmg_cfg_regs: configuration register file behind the plain write port.
// Depends on tmg_pkg (register indexes, tmg_cfg_t).
module tmg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tmg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tmg_pkg::tmg_cfg_t                cfg
);
  import tmg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CRITICAL_TEMP:    cfg.critical_temp    <= cfg_data[TEMP_W-1:0];
        CFG_GUARD_BAND:       cfg.guard_band       <= cfg_data[TEMP_W-1:0];
        CFG_AMBIENT_TEMP:     cfg.ambient_temp     <= cfg_data[TEMP_W-1:0];
        CFG_THERMAL_RES:      cfg.thermal_res      <= cfg_data[RES_W-1:0];
        CFG_CRITICAL_DELTA:   cfg.critical_delta   <= cfg_data[TEMP_W-1:0];
        CFG_HYSTERESIS_DELTA: cfg.hysteresis_delta <= cfg_data[TEMP_W-1:0];
        CFG_COOLDOWN_NS:      cfg.cooldown_ns      <= cfg_data[CD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/tmg_ctrl.sv -----
// tmg_ctrl: sequencer for the timestamp RAM: clearing pass, check reads, record writes.
// Depends on tmg_pkg (tmg_state_t, tmg_ctl_t, operation codes).
module tmg_ctrl #(
  parameter int NUM_CORES = tmg_pkg::NUM_CORES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         operation,
  output tmg_pkg::tmg_ctl_t            ctl,
  output logic [$clog2(NUM_CORES)-1:0] clr_addr
);
  import tmg_pkg::*;

  localparam int IDX_W = $clog2(NUM_CORES);

  tmg_state_t       state, state_next;
  logic [IDX_W-1:0] clr_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    unique case (state)
      ST_CLEAR: begin
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == IDX_W'(NUM_CORES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (operation == OP_RECORD) ? ST_WR_FROM : ST_RD_TO;
        end
      end
      ST_RD_TO:   state_next = ST_RD_FROM;
      ST_RD_FROM: state_next = ST_EVAL;
      ST_EVAL:    state_next = ST_IDLE;
      ST_WR_FROM: state_next = ST_WR_TO;
      ST_WR_TO:   state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_CLEAR:   begin ctl.busy = 1'b1; ctl.clear   = 1'b1; end
      ST_IDLE:    ctl.busy = 1'b0;
      ST_RD_TO:   begin ctl.busy = 1'b1; ctl.rd_to   = 1'b1; end
      ST_RD_FROM: begin ctl.busy = 1'b1; ctl.rd_from = 1'b1; end
      ST_EVAL:    begin ctl.busy = 1'b1; ctl.eval    = 1'b1; end
      ST_WR_FROM: begin ctl.busy = 1'b1; ctl.wr_from = 1'b1; end
      ST_WR_TO:   begin ctl.busy = 1'b1; ctl.wr_to   = 1'b1; end
      default:    ctl.busy = 1'b1;
    endcase
  end

endmodule

// ----- rtl/thermal_migration_gate_core.sv -----
// Channel   Handshake                  Payload
// item      start & !busy              item   (tmg_item_t)
// result    done, one cycle, no stall  result (tmg_result_t)
// config    cfg_write                  cfg_index, cfg_data
//
// Check: accepted, then read to_core stamp, read from_core stamp, evaluate; done is
// registered from the evaluate step, and a new start is taken while done is high.
// Record: write from_core stamp, then to_core stamp; done is registered from the last write.
// This order comes from the one read port and the one write port of the timestamp RAM.
// After reset a clearing pass over all NUM_CORES entries sets every stamp to all ones;
// busy is high meanwhile. Results cannot be held off by the receiver.
//
// Top level: config regs, sequencer, timestamp RAM and the check datapath.
// Depends on tmg_pkg, tmg_ram, tmg_cfg_regs, tmg_ctrl.
module thermal_migration_gate_core #(
  parameter int NUM_CORES = tmg_pkg::NUM_CORES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tmg_pkg::tmg_item_t             item,
  output logic                           done,
  output tmg_pkg::tmg_result_t           result,
  input  logic                           cfg_write,
  input  logic [tmg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmg_pkg::*;

  localparam int IDX_W = $clog2(NUM_CORES);

  tmg_cfg_t          cfg;
  tmg_ctl_t          ctl;
  logic [IDX_W-1:0]  clr_addr;
  tmg_item_t         item_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [TIME_W-1:0] ram_wdata, ram_rdata;

  logic [IDX_W-1:0]  from_idx, to_idx;
  logic              from_ok, to_ok;

  logic [PROD_W-1:0] prod_s, prod_d;
  logic [TEMP_W-1:0] spred, dpred;
  logic              cool_to;

  logic [TEMP_W-1:0] lim_base, eff_lim, need;
  logic              src_crit, cool_from, drop_low;
  logic signed [TEMP_W:0] drop;
  tmg_result_t       eval_res;

  tmg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tmg_ctrl #(.NUM_CORES(NUM_CORES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .ctl       (ctl),
    .clr_addr  (clr_addr)
  );

  assign busy = ctl.busy;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
  end

  assign from_idx = IDX_W'(item_q.from_core);
  assign to_idx   = IDX_W'(item_q.to_core);
  assign from_ok  = {{(32-CORE_W){1'b0}}, item_q.from_core} < 32'(NUM_CORES);
  assign to_ok    = {{(32-CORE_W){1'b0}}, item_q.to_core} < 32'(NUM_CORES);

  // one transaction at a time: reads and writes never overlap on an entry
  assign ram_we    = ctl.clear || (ctl.wr_from && from_ok) || (ctl.wr_to && to_ok);
  assign ram_waddr = ctl.clear ? clr_addr : (ctl.wr_from ? from_idx : to_idx);
  assign ram_wdata = ctl.clear ? '1 : item_q.now_ns;
  assign ram_raddr = ctl.rd_to ? to_idx : from_idx;

  tmg_ram #(.WIDTH(TIME_W), .DEPTH(NUM_CORES)) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // products settle during RD_TO, predictions and dest cooling during RD_FROM
  always_ff @(posedge clk) begin
    prod_s  <= PROD_W'(cfg.thermal_res) * PROD_W'(item_q.source_power);
    prod_d  <= PROD_W'(cfg.thermal_res) * PROD_W'(item_q.dest_power);
    spred   <= tmg_predict(item_q.src_temp, prod_s, item_q.source_power_ok,
                           cfg.thermal_res, cfg.ambient_temp);
    dpred   <= tmg_predict(item_q.dest_temp, prod_d, item_q.dest_power_ok,
                           cfg.thermal_res, cfg.ambient_temp);
    if (ctl.rd_from) begin
      cool_to <= tmg_cooling(ram_rdata, item_q.now_ns, cfg.cooldown_ns);
    end
  end

  // evaluation, RAM now returns the from_core stamp
  always_comb begin
    lim_base  = (cfg.critical_temp >= cfg.guard_band) ?
                (cfg.critical_temp - cfg.guard_band) : '0;
    eff_lim   = (lim_base > cfg.ambient_temp) ? lim_base : cfg.ambient_temp;
    src_crit  = (cfg.critical_temp != '0) && (spred >= eff_lim);
    need      = src_crit ? cfg.critical_delta : cfg.hysteresis_delta;
    drop      = signed'({1'b0, spred}) - signed'({1'b0, dpred});
    drop_low  = drop < signed'({1'b0, need});
    cool_from = tmg_cooling(ram_rdata, item_q.now_ns, cfg.cooldown_ns);

    eval_res.allowed      = 1'b1;
    eval_res.block_reason = REASON_NONE;
    if (from_ok && to_ok) begin
      if (cool_to) begin
        eval_res.allowed      = 1'b0;
        eval_res.block_reason = REASON_DEST_COOL;
      end else if (!src_crit && cool_from) begin
        eval_res.allowed      = 1'b0;
        eval_res.block_reason = REASON_SRC_COOL;
      end else if ((need != '0) && drop_low) begin
        eval_res.allowed      = 1'b0;
        eval_res.block_reason = REASON_DROP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.eval || ctl.wr_to;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_to) begin
      result.allowed      <= 1'b1;
      result.block_reason <= REASON_NONE;
    end else if (ctl.eval) begin
      result <= eval_res;
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.eval || ctl.wr_to))
    else $error("result strobe without a finished transaction");

  a_idle_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(ctl.clear) |-> done)
    else $error("returned to idle without delivering a result");

  a_reason_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.allowed == (result.block_reason == REASON_NONE)))
    else $error("allowed flag disagrees with block reason");

endmodule
